FILE: hw/rtl/vector3_arithmetic_unit_defines.svh
// assertion macros for the vector arithmetic unit
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define V3A_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk outside reset
`define V3A_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/v3a_pkg.sv
// shared types, constants and helpers for the vector arithmetic unit
`timescale 1ns / 1ps
package v3a_pkg;

  localparam int DW  = 32;          // data width, signed fixed point
  localparam int FB  = 16;          // fraction bits
  localparam int SQW = 2 * DW;      // sum of squares width
  localparam int XW  = 2 * DW + 2;  // exact sum of three products
  localparam int NW  = DW + FB;     // shifted dividend width
  localparam int QW  = DW - 1;      // quotient bits below saturation

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_SCALE  = 4'd2,
    OP_DIV    = 4'd3,
    OP_DOT    = 4'd4,
    OP_CROSS  = 4'd5,
    OP_MAG    = 4'd6,
    OP_SQUARE = 4'd7,
    OP_NORM   = 4'd8,
    OP_DIST   = 4'd9
  } op_t;

  typedef struct packed {
    logic [3:0]           op;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] az;
    logic signed [DW-1:0] bx;
    logic signed [DW-1:0] by;
    logic signed [DW-1:0] bz;
    logic signed [DW-1:0] scalar_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] rz;
    logic signed [DW-1:0] scalar_out;
    logic                 error;
  } out_item_t;

  // carried alongside the square root
  typedef struct packed {
    logic [3:0]           op;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] az;
    logic signed [DW-1:0] s;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] rz;
    logic signed [DW-1:0] sc;
  } sq_side_t;

  // carried alongside the divider
  typedef struct packed {
    logic [3:0]           op;
    logic                 err;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] rz;
    logic signed [DW-1:0] sc;
  } dv_side_t;

  function automatic logic signed [XW-1:0] ext_d(input logic signed [DW-1:0] v);
    ext_d = {{(XW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] ext_p(input logic signed [SQW-1:0] v);
    ext_p = {{(XW-SQW){v[SQW-1]}}, v};
  endfunction

  function automatic logic signed [DW-1:0] sat_x(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = $signed({{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      sat_x = hi[DW-1:0];
    end else if (v < lo) begin
      sat_x = lo[DW-1:0];
    end else begin
      sat_x = v[DW-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/vector3_arithmetic_unit.sv
// top level of the pipelined 3d vector arithmetic unit
// Input channel item_valid/item_ready/item carries an opcode, vectors a and b
// and a scalar in signed Q16.16; output channel result_valid/result_ready/
// result carries rx, ry, rz, scalar_out and the error flag, one result per item.
// Every operation runs through the same pipeline: five front stages (input
// register, operand select, six 32x32 products, exact sums, saturation),
// sixteen square root stages of two root bits each, sixteen divider stages of
// two quotient bits each (one in the last) and one output register. Results
// leave in order. One item is accepted per cycle while item_ready is high.
// The whole pipeline advances together: it moves whenever the output register
// is empty or being taken, so item_ready is low only while a result waits
// and result_ready is low. A stall freezes every stage in place.
// Synchronous reset clears all valid bits; no result is shown after reset
// until items arrive. There are no configuration registers.
`include "vector3_arithmetic_unit_defines.svh"
`timescale 1ns / 1ps
module vector3_arithmetic_unit import v3a_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  logic           fr_valid;
  logic [SQW-1:0] fr_rad;
  sq_side_t       fr_side;

  v3a_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (item_valid),
    .item       (item),
    .valid      (fr_valid),
    .rad        (fr_rad),
    .side       (fr_side)
  );

  logic          sq_valid;
  logic [DW-1:0] sq_root;
  sq_side_t      sq_side;

  v3a_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .rad       (fr_rad),
    .side_in   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // divider setup: divisor, signs, magnitude result, error
  logic signed [DW-1:0] av [3];
  logic [DW-1:0]        aabs [3];
  logic [DW-1:0]        sabs;
  logic [NW-1:0]        num [3];
  logic [DW-1:0]        den;
  logic [2:0]           neg;
  dv_side_t             dv_in;

  assign av[0] = sq_side.ax;
  assign av[1] = sq_side.ay;
  assign av[2] = sq_side.az;

  always_comb begin
    sabs = sq_side.s[DW-1] ? $unsigned(-sq_side.s) : $unsigned(sq_side.s);
    for (int l = 0; l < 3; l++) begin
      aabs[l] = av[l][DW-1] ? $unsigned(-av[l]) : $unsigned(av[l]);
      num[l]  = {aabs[l], {FB{1'b0}}};
      neg[l]  = av[l][DW-1] ^ ((sq_side.op == OP_DIV) && sq_side.s[DW-1]);
    end
    den      = (sq_side.op == OP_NORM) ? sq_root : sabs;
    dv_in.op = sq_side.op;
    dv_in.rx = sq_side.rx;
    dv_in.ry = sq_side.ry;
    dv_in.rz = sq_side.rz;
    dv_in.sc = sq_side.sc;
    dv_in.err = 1'b0;
    case (sq_side.op)
      OP_MAG, OP_DIST: begin
        dv_in.sc = sq_root[DW-1] ? $signed({1'b0, {(DW-1){1'b1}}}) : $signed(sq_root);
      end
      OP_DIV:  dv_in.err = (sq_side.s == '0);
      OP_NORM: dv_in.err = (sq_root == '0);
      default: dv_in.err = 1'b0;
    endcase
  end

  logic                 dv_valid;
  logic signed [DW-1:0] dv_q [3];
  dv_side_t             dv_side;

  v3a_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .num       (num),
    .den       (den),
    .neg       (neg),
    .side_in   (dv_in),
    .out_valid (dv_valid),
    .q         (dv_q),
    .side_out  (dv_side)
  );

  out_item_t res_c;

  always_comb begin
    res_c.rx         = dv_side.rx;
    res_c.ry         = dv_side.ry;
    res_c.rz         = dv_side.rz;
    res_c.scalar_out = dv_side.sc;
    res_c.error      = 1'b0;
    if (dv_side.err) begin
      res_c.rx         = '0;
      res_c.ry         = '0;
      res_c.rz         = '0;
      res_c.scalar_out = '0;
      res_c.error      = 1'b1;
    end else if (dv_side.op == OP_DIV || dv_side.op == OP_NORM) begin
      res_c.rx = dv_q[0];
      res_c.ry = dv_q[1];
      res_c.rz = dv_q[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv_valid;
    end
    if (en) begin
      result <= res_c;
    end
  end

  `V3A_ASSERT_IMPL(a_err_zero, result_valid && result.error, result.rx == '0 && result.ry == '0 && result.rz == '0 && result.scalar_out == '0, "error result with nonzero fields")
  `V3A_ASSERT_IMPL(a_err_op, dv_valid && dv_side.err, dv_side.op == OP_DIV || dv_side.op == OP_NORM, "error flagged for an op that cannot fail")
  `V3A_ASSERT_IMPL(a_field_excl, result_valid && (result.rx != '0 || result.ry != '0 || result.rz != '0), result.scalar_out == '0, "vector and scalar result both nonzero")
  `V3A_ASSERT_NEXT(a_advance, en && dv_valid, result_valid, "finished item lost at the output register")

endmodule

FILE: hw/rtl/v3a_front.sv
// front stages: operand select, products, sums and saturation
`timescale 1ns / 1ps
module v3a_front import v3a_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           item_valid,
  input  in_item_t       item,
  output logic           valid,
  output logic [SQW-1:0] rad,
  output sq_side_t       side
);

  // stage 0: input register
  logic     v0;
  in_item_t it0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= item_valid;
    end
    if (en) begin
      it0 <= item;
    end
  end

  // stage 1: add/sub, difference and multiplier operands
  logic signed [DW-1:0] a [3];
  logic signed [DW-1:0] b [3];
  logic signed [DW-1:0] lin [3];
  logic signed [DW-1:0] vsq [3];
  logic signed [DW-1:0] ma [6];
  logic signed [DW-1:0] mb [6];
  logic signed [DW:0]   sum_w [3];
  logic signed [DW:0]   dif_w [3];
  logic signed [DW-1:0] dsat [3];

  assign a[0] = it0.ax;
  assign a[1] = it0.ay;
  assign a[2] = it0.az;
  assign b[0] = it0.bx;
  assign b[1] = it0.by;
  assign b[2] = it0.bz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_w[k] = {a[k][DW-1], a[k]} + {b[k][DW-1], b[k]};
      dif_w[k] = {a[k][DW-1], a[k]} - {b[k][DW-1], b[k]};
      dsat[k]  = sat_x($signed({{(XW-DW-1){dif_w[k][DW]}}, dif_w[k]}));
      lin[k]   = (it0.op == OP_ADD) ?
                 sat_x($signed({{(XW-DW-1){sum_w[k][DW]}}, sum_w[k]})) : dsat[k];
      vsq[k]   = (it0.op == OP_DIST) ? dsat[k] : a[k];
    end
    for (int k = 0; k < 6; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    case (it0.op)
      OP_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = a[k];
          mb[k] = it0.scalar_in;
        end
      end
      OP_DOT: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = a[k];
          mb[k] = b[k];
        end
      end
      OP_CROSS: begin
        // lane k gives the positive term, lane k+3 the negative one
        ma[0] = a[1]; mb[0] = b[2];
        ma[1] = a[2]; mb[1] = b[0];
        ma[2] = a[0]; mb[2] = b[1];
        ma[3] = a[2]; mb[3] = b[1];
        ma[4] = a[0]; mb[4] = b[2];
        ma[5] = a[1]; mb[5] = b[0];
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = vsq[k];
          mb[k] = vsq[k];
        end
      end
    endcase
  end

  logic                 v1;
  logic [3:0]           op1;
  logic signed [DW-1:0] a1 [3];
  logic signed [DW-1:0] s1;
  logic signed [DW-1:0] lin1 [3];
  logic signed [DW-1:0] ma1 [6];
  logic signed [DW-1:0] mb1 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      op1 <= it0.op;
      s1  <= it0.scalar_in;
      for (int k = 0; k < 3; k++) begin
        a1[k]   <= a[k];
        lin1[k] <= lin[k];
      end
      for (int k = 0; k < 6; k++) begin
        ma1[k] <= ma[k];
        mb1[k] <= mb[k];
      end
    end
  end

  // stage 2: six products
  logic                  v2;
  logic [3:0]            op2;
  logic signed [DW-1:0]  a2 [3];
  logic signed [DW-1:0]  s2;
  logic signed [DW-1:0]  lin2 [3];
  logic signed [SQW-1:0] p2 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2 <= op1;
      s2  <= s1;
      for (int k = 0; k < 3; k++) begin
        a2[k]   <= a1[k];
        lin2[k] <= lin1[k];
      end
      for (int k = 0; k < 6; k++) begin
        p2[k] <= ma1[k] * mb1[k];
      end
    end
  end

  // stage 3: exact sums
  logic signed [XW-1:0] t_c [3];
  logic signed [XW-1:0] dsum_c;
  logic [SQW-1:0]       uss_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_c[k] = (op2 == OP_CROSS) ? ext_p(p2[k]) - ext_p(p2[k+3]) : ext_p(p2[k]);
    end
    dsum_c = ext_p(p2[0]) + ext_p(p2[1]) + ext_p(p2[2]);
    // squares are never negative, so the sum fits unsigned
    uss_c  = $unsigned(p2[0]) + $unsigned(p2[1]) + $unsigned(p2[2]);
  end

  logic                 v3;
  logic [3:0]           op3;
  logic signed [DW-1:0] a3 [3];
  logic signed [DW-1:0] s3;
  logic signed [DW-1:0] lin3 [3];
  logic signed [XW-1:0] t3 [3];
  logic signed [XW-1:0] dsum3;
  logic [SQW-1:0]       uss3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      op3   <= op2;
      s3    <= s2;
      dsum3 <= dsum_c;
      uss3  <= uss_c;
      for (int k = 0; k < 3; k++) begin
        a3[k]   <= a2[k];
        lin3[k] <= lin2[k];
        t3[k]   <= t_c[k];
      end
    end
  end

  // stage 4: floor, saturate, pick the result fields
  logic signed [DW-1:0] rv [3];
  logic signed [DW-1:0] sc_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (op3)
        OP_ADD, OP_SUB:    rv[k] = lin3[k];
        OP_SCALE, OP_CROSS: rv[k] = sat_x(t3[k] >>> FB);
        default:           rv[k] = '0;
      endcase
    end
    case (op3)
      OP_DOT:    sc_c = sat_x(dsum3 >>> FB);
      OP_SQUARE: sc_c = sat_x($signed({{(XW-SQW){1'b0}}, uss3 >> FB}));
      default:   sc_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v3;
    end
    if (en) begin
      rad     <= uss3;
      side.op <= op3;
      side.ax <= a3[0];
      side.ay <= a3[1];
      side.az <= a3[2];
      side.s  <= s3;
      side.rx <= rv[0];
      side.ry <= rv[1];
      side.rz <= rv[2];
      side.sc <= sc_c;
    end
  end

endmodule

FILE: hw/rtl/v3a_sqrt.sv
// pipelined integer square root, two root bits per stage
`timescale 1ns / 1ps
module v3a_sqrt import v3a_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [SQW-1:0] rad,
  input  sq_side_t       side_in,
  output logic           out_valid,
  output logic [DW-1:0]  root,
  output sq_side_t       side_out
);

  localparam int NS  = DW / 2;
  localparam int RMW = DW + 4;

  logic           v   [NS];
  logic [RMW-1:0] rem [NS];
  logic [DW-1:0]  rt  [NS];
  logic [SQW-1:0] rd  [NS];
  sq_side_t       sd  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_st
    logic           v_i;
    logic [RMW-1:0] rem_i;
    logic [DW-1:0]  rt_i;
    logic [SQW-1:0] rd_i;
    sq_side_t       sd_i;
    logic [RMW-1:0] rem_n;
    logic [RMW-1:0] trial;
    logic [DW-1:0]  rt_n;
    logic [SQW-1:0] rd_n;

    if (j == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = '0;
      assign rt_i  = '0;
      assign rd_i  = rad;
      assign sd_i  = side_in;
    end else begin : g_next
      assign v_i   = v[j-1];
      assign rem_i = rem[j-1];
      assign rt_i  = rt[j-1];
      assign rd_i  = rd[j-1];
      assign sd_i  = sd[j-1];
    end

    always_comb begin
      rem_n = rem_i;
      rt_n  = rt_i;
      rd_n  = rd_i;
      trial = '0;
      for (int k = 0; k < 2; k++) begin
        rem_n = {rem_n[RMW-3:0], rd_n[SQW-1 -: 2]};
        rd_n  = {rd_n[SQW-3:0], 2'b00};
        trial = {{(RMW-DW-2){1'b0}}, rt_n, 2'b01};
        if (rem_n >= trial) begin
          rem_n = rem_n - trial;
          rt_n  = {rt_n[DW-2:0], 1'b1};
        end else begin
          rt_n  = {rt_n[DW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v_i;
      end
      if (en) begin
        rem[j] <= rem_n;
        rt[j]  <= rt_n;
        rd[j]  <= rd_n;
        sd[j]  <= sd_i;
      end
    end
  end

  assign out_valid = v[NS-1];
  assign root      = rt[NS-1];
  assign side_out  = sd[NS-1];

endmodule

FILE: hw/rtl/v3a_div.sv
// pipelined three-lane restoring divider with saturation, two bits per stage, one in the last
`timescale 1ns / 1ps
module v3a_div import v3a_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [NW-1:0]        num [3],
  input  logic [DW-1:0]        den,
  input  logic [2:0]           neg,
  input  dv_side_t             side_in,
  output logic                 out_valid,
  output logic signed [DW-1:0] q [3],
  output dv_side_t             side_out
);

  localparam int ND = (QW + 1) / 2;
  localparam int HW = NW - QW;

  logic          v    [ND];
  logic [DW-1:0] dn   [ND];
  logic [2:0]    ovf  [ND];
  logic [2:0]    ng   [ND];
  logic [DW-1:0] rem  [ND][3];
  logic [QW-1:0] nb   [ND][3];
  logic [QW-1:0] qq   [ND][3];
  dv_side_t      sd   [ND];

  for (genvar j = 0; j < ND; j++) begin : g_st
    logic          v_i;
    logic [DW-1:0] dn_i;
    logic [2:0]    ovf_i;
    logic [2:0]    ng_i;
    logic [DW-1:0] rem_i [3];
    logic [QW-1:0] nb_i  [3];
    logic [QW-1:0] qq_i  [3];
    dv_side_t      sd_i;
    logic [DW-1:0] rem_n [3];
    logic [QW-1:0] nb_n  [3];
    logic [QW-1:0] qq_n  [3];
    logic [DW:0]   r;

    if (j == 0) begin : g_first
      logic [DW-1:0] hi [3];
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          // quotient saturates when the dividend top part reaches the divisor
          hi[l]    = {{(DW-HW){1'b0}}, num[l][NW-1 -: HW]};
          ovf_i[l] = (hi[l] >= den);
          rem_i[l] = hi[l];
          nb_i[l]  = num[l][QW-1:0];
          qq_i[l]  = '0;
        end
      end
      assign v_i  = in_valid;
      assign dn_i = den;
      assign ng_i = neg;
      assign sd_i = side_in;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = rem[j-1][l];
          nb_i[l]  = nb[j-1][l];
          qq_i[l]  = qq[j-1][l];
        end
      end
      assign v_i   = v[j-1];
      assign dn_i  = dn[j-1];
      assign ovf_i = ovf[j-1];
      assign ng_i  = ng[j-1];
      assign sd_i  = sd[j-1];
    end

    always_comb begin
      r = '0;
      for (int l = 0; l < 3; l++) begin
        rem_n[l] = rem_i[l];
        nb_n[l]  = nb_i[l];
        qq_n[l]  = qq_i[l];
        for (int k = 0; k < 2; k++) begin
          if (j * 2 + k < QW) begin
            r       = {rem_n[l], nb_n[l][QW-1]};
            nb_n[l] = {nb_n[l][QW-2:0], 1'b0};
            if (r >= {1'b0, dn_i}) begin
              r       = r - {1'b0, dn_i};
              qq_n[l] = {qq_n[l][QW-2:0], 1'b1};
            end else begin
              qq_n[l] = {qq_n[l][QW-2:0], 1'b0};
            end
            rem_n[l] = r[DW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v_i;
      end
      if (en) begin
        dn[j]  <= dn_i;
        ovf[j] <= ovf_i;
        ng[j]  <= ng_i;
        sd[j]  <= sd_i;
        for (int l = 0; l < 3; l++) begin
          rem[j][l] <= rem_n[l];
          nb[j][l]  <= nb_n[l];
          qq[j][l]  <= qq_n[l];
        end
      end
    end
  end

  // sign and saturation of the truncated quotient
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (ovf[ND-1][l]) begin
        q[l] = ng[ND-1][l] ? $signed({1'b1, {QW{1'b0}}}) : $signed({1'b0, {QW{1'b1}}});
      end else if (ng[ND-1][l]) begin
        q[l] = -$signed({1'b0, qq[ND-1][l]});
      end else begin
        q[l] = $signed({1'b0, qq[ND-1][l]});
      end
    end
  end

  assign out_valid = v[ND-1];
  assign side_out  = sd[ND-1];

endmodule
